FILE: hdl/utoa_pkg.sv
// Shared types and constants for the unsigned-to-decimal ASCII unit.
// No dependencies.
`timescale 1ns / 1ps

package utoa_pkg;

  localparam int unsigned ValueBitsDefault = 32;
  localparam logic [5:0]  AsciiZero        = 6'd48;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } utoa_state_e;

  typedef struct packed {
    logic load;
    logic dabble;
    logic emit;
  } utoa_ctrl_t;

endpackage

FILE: hdl/unsigned_to_decimal_ascii_unit.sv
// Channel  | ports                         | transfer
// ---------+-------------------------------+------------------------------------
// command  | start, busy, value_i          | start && !busy at clock edge
// result   | strobe_o, digit_char_o, last_o| one digit per cycle, no back-pressure
//
// One transaction runs serial BCD conversion, one bit per cycle in the shift
// register, then digit readout (leading zeros are scanned but not sent).
// busy is high through conversion and readout. The last digit leaves its
// register in the first idle cycle, where the next start is taken.
// Reset clears the controller only. Results cannot be stalled.
// Depends on utoa_pkg and utoa_dabble.
`timescale 1ns / 1ps

module unsigned_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_BITS = utoa_pkg::ValueBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  strobe_o,
  output logic [5:0]            digit_char_o,
  output logic                  last_o
);
  import utoa_pkg::*;

  localparam int unsigned NumDigits = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned CntW      = $clog2(VALUE_BITS);

  utoa_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            started_q, started_d;
  logic            strobe_q, strobe_d;
  logic [5:0]      char_q, char_d;
  logic            last_q, last_d;
  utoa_ctrl_t      ctrl;
  logic [3:0]      top_digit;
  logic            at_last;

  utoa_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NumDigits)
  ) u_dabble (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .value_i     (value_i),
    .top_digit_o (top_digit)
  );

  assign at_last = (cnt_q == CntW'(NumDigits - 1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    strobe_d  = 1'b0;
    char_d    = char_q;
    last_d    = 1'b0;
    ctrl      = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          ctrl.load = 1'b1;
          cnt_d     = '0;
          started_d = 1'b0;
          state_d   = StConv;
        end
      end
      StConv: begin
        ctrl.dabble = 1'b1;
        if (cnt_q == CntW'(VALUE_BITS - 1)) begin
          cnt_d   = '0;
          state_d = StEmit;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StEmit: begin
        ctrl.emit = 1'b1;
        strobe_d  = (top_digit != 4'd0) || started_q || at_last;
        started_d = started_q || strobe_d;
        char_d    = AsciiZero + {2'b00, top_digit};
        last_d    = at_last;
        cnt_d     = cnt_q + 1'b1;
        if (at_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      started_q <= 1'b0;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      strobe_q  <= strobe_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign busy         = (state_q != StIdle);
  assign strobe_o     = strobe_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (digit_char_o >= 6'd48) && (digit_char_o <= 6'd57))
    else $error("digit character out of range");

  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(state_q == StEmit))
    else $error("result strobe outside readout");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> !busy || $past(start && !busy))
    else $error("last digit sent while still converting");

  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o)
    else $error("last flag without strobe");

endmodule

FILE: hdl/utoa_dabble.sv
// Bit-serial binary to BCD shift register (shift-and-add-3) plus digit readout shift.
// Depends on utoa_pkg.
`timescale 1ns / 1ps

module utoa_dabble #(
  parameter int unsigned VALUE_BITS = utoa_pkg::ValueBitsDefault,
  parameter int unsigned NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1
) (
  input  logic                    clk_i,
  input  utoa_pkg::utoa_ctrl_t    ctrl_i,
  input  logic [VALUE_BITS-1:0]   value_i,
  output logic [3:0]              top_digit_o
);
  import utoa_pkg::*;

  localparam int unsigned BcdW = 4 * NUM_DIGITS;

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [BcdW-1:0]       bcd_q, bcd_d, adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    val_d = val_q;
    bcd_d = bcd_q;
    if (ctrl_i.load) begin
      val_d = value_i;
      bcd_d = '0;
    end else if (ctrl_i.dabble) begin
      val_d = val_q << 1;
      bcd_d = {adj[BcdW-2:0], val_q[VALUE_BITS-1]};
    end else if (ctrl_i.emit) begin
      bcd_d = bcd_q << 4;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[BcdW-1 -: 4];

endmodule

FILE: tb/sv/unsigned_to_decimal_ascii_unit_tb.sv
// Self-checking testbench for unsigned_to_decimal_ascii_unit: directed and random
// values in, predicted decimal ASCII digits checked per strobe, in order.
// Depends on utoa_pkg and the unsigned_to_decimal_ascii_unit RTL.
`timescale 1ns / 1ps

module unsigned_to_decimal_ascii_unit_tb;
  import utoa_pkg::*;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [5:0] digit_char;
    logic       last;
  } digit_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [ValueBits-1:0] value_i;
  logic                 strobe_o;
  logic [5:0]           digit_char_o;
  logic                 last_o;

  logic [ValueBits-1:0] pending_values[$];
  digit_t               expected_digits[$];
  int unsigned          total_items;
  int unsigned          accepted_count = 0;
  int unsigned          loaded_count = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count = 0;
  bit                   holding = 1'b0;
  int unsigned          gap_left = 0;
  logic [ValueBits-1:0] cur_value = '0;

  unsigned_to_decimal_ascii_unit #(
    .VALUE_BITS(ValueBits)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .digit_char_o(digit_char_o),
    .last_o      (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Decimal digits of one value, most significant first, onto the expected queue.
  task automatic queue_decimal_digits(input logic [ValueBits-1:0] number);
    logic [63:0] rest;
    logic [3:0]  digits[20];
    int          count;
    digit_t      d;
    rest  = 64'(number);
    count = 0;
    if (rest == 0) begin
      digits[0] = 4'd0;
      count = 1;
    end
    while (rest != 0) begin
      digits[count] = 4'(rest % 10);
      rest = rest / 10;
      count++;
    end
    for (int k = count - 1; k >= 0; k--) begin
      d.digit_char = AsciiZero + 6'(digits[k]);
      d.last       = (k == 0);
      expected_digits.push_back(d);
    end
  endtask

  function automatic logic [ValueBits-1:0] random_value_of_length(input int unsigned ndigits);
    longint unsigned lo;
    longint unsigned hi;
    lo = 1;
    for (int i = 1; i < ndigits; i++) lo = lo * 10;
    hi = (ndigits == 1) ? 9 : lo * 10 - 1;
    if (ndigits == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return ValueBits'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
  endfunction

  // Monitor: command acceptance, prediction and digit checks.
  always @(posedge clk_i) begin
    digit_t exp_d;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("unsigned_to_decimal_ascii_unit_tb failed");
      $finish;
    end else if (rst_ni) begin
      if (start && !busy) begin
        queue_decimal_digits(value_i);
        accepted_count++;
      end
      if (strobe_o) begin
        if (expected_digits.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                   $time, digit_char_o, last_o);
        end else begin
          exp_d = expected_digits.pop_front();
          if (digit_char_o !== exp_d.digit_char) begin
            mismatch_count++;
            $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                     $time, exp_d.digit_char, digit_char_o);
          end
          if (last_o !== exp_d.last) begin
            mismatch_count++;
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, exp_d.last, last_o);
          end
        end
      end
    end
  end

  // Driver: holds start until the transaction is taken, then pauses for a random gap counted only while not busy.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      value_i <= '0;
    end else begin
      if (holding && (accepted_count == loaded_count)) begin
        holding   = 1'b0;
        gap_left  = (((loaded_count / 16) % 3) == 2) ? 0 : $urandom_range(0, 3);
      end
      if (!holding) begin
        if (gap_left != 0) begin
          if (!busy) gap_left--;
        end else if (pending_values.size() != 0) begin
          cur_value = pending_values.pop_front();
          holding   = 1'b1;
          loaded_count++;
        end
      end
      start   <= holding;
      value_i <= holding ? cur_value : ValueBits'($urandom);
    end
  end

  initial begin
    int unsigned pick;
    rst_ni  = 1'b0;

    pending_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000,
                       32'd12345, 32'd999999999, 32'd1000000000, 32'd2147483647,
                       32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd4000000000,
                       32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0, 32'd7};
    for (int i = 0; i < 91; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) pending_values.push_back(ValueBits'($urandom));
      else if (pick == 1) pending_values.push_back(ValueBits'($urandom_range(0, 2)));
      else pending_values.push_back(random_value_of_length($urandom_range(1, 10)));
    end
    total_items = pending_values.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_count != total_items) @(posedge clk_i);
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && expected_digits.size() == 0) begin
      $display("unsigned_to_decimal_ascii_unit_tb passed");
    end else begin
      $display("unsigned_to_decimal_ascii_unit_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/utoa_pkg.sv
hdl/utoa_dabble.sv
hdl/unsigned_to_decimal_ascii_unit.sv
tb/sv/unsigned_to_decimal_ascii_unit_tb.sv
